// File: design/lpd_pkg.sv
package lpd_pkg;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_STRIP    = 5'b00010,
    S_DIV_GO   = 5'b00100,
    S_DIV_WAIT = 5'b01000,
    S_FINISH   = 5'b10000
  } lpd_state_e;

  // Distinct prime count saturates at two: only "fewer than two" matters
  localparam int unsigned DistBits = 2;
  localparam logic [DistBits-1:0] DistSat = 2'd2;

endpackage

// File: design/lpd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
module lpd_div #(
  parameter int unsigned W = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CntBits = $clog2(W + 1);

  logic [W-1:0]       qsh_q, qsh_d;
  logic [W-1:0]       rem_q, rem_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [W:0]         trial;
  logic [W:0]         diff;
  logic               ge;

  // dividend shifts out of the top while quotient bits enter at the bottom
  assign trial = {rem_q, qsh_q[W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = (trial >= {1'b0, divisor_i});

  always_comb begin
    qsh_d  = qsh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      qsh_d = dividend_i;
      rem_d = '0;
      cnt_d = CntBits'(W);
      run_d = 1'b1;
    end else if (run_q) begin
      qsh_d = {qsh_q[W-2:0], ge};
      rem_d = ge ? diff[W-1:0] : trial[W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qsh_q <= qsh_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = qsh_q;
  assign rem_o  = rem_q;

  // a done pulse closes a run and is never back to back
  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q && $past(run_q))
    else $error("divider done without a run");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held over two cycles");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> cnt_q != '0)
    else $error("divider running with empty bit count");

endmodule

// File: design/largest_prime_divisor_top.sv
// Largest prime divisor by trial division, bit-serial divider.
// Factors of two are stripped first, then odd trial divisions run one at a time on the
//   divider; trial divisions ~ sqrt(|value|)/2 + prime-factor multiplicity.
// Throughput: one item at a time; busy_o is high from accept until done_o rises.
// Reset: asynchronous, active low, back to idle; results show on done_o, no stall.
module largest_prime_divisor_top
  import lpd_pkg::*;
#(
  parameter int unsigned MAG_BITS = 47
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [MAG_BITS:0]   value_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic signed [MAG_BITS:0]   answer_o
);

  localparam int unsigned W = MAG_BITS + 1;

  lpd_state_e state_q, state_d;

  // n: part still unfactored, d: current odd trial divisor
  logic [W-1:0]          n_q, n_d;
  logic [W-1:0]          d_q, d_d;
  logic [W-1:0]          largest_q, largest_d;
  logic [DistBits-1:0]   dist_q, dist_d;
  logic                  found_q, found_d;
  logic                  done_q, done_d;
  logic [W-1:0]          answer_q, answer_d;

  logic [W-1:0]          mag;
  logic                  div_start;
  logic                  div_done;
  logic [W-1:0]          quot;
  logic [W-1:0]          rem;
  logic [DistBits-1:0]   dist_inc;
  logic [DistBits-1:0]   dist_fin;
  logic [W-1:0]          largest_fin;

  // two's complement magnitude; the most negative value maps to 2^MAG_BITS exactly
  assign mag = value_i[MAG_BITS] ? (~$unsigned(value_i) + W'(1)) : $unsigned(value_i);

  assign dist_inc  = (dist_q == DistSat) ? DistSat : dist_q + 1'b1;
  assign div_start = (state_q == S_DIV_GO);

  lpd_div #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // a leftover above one is the final (largest) prime
  always_comb begin
    dist_fin    = dist_q;
    largest_fin = largest_q;
    if (n_q > W'(1)) begin
      dist_fin    = dist_inc;
      largest_fin = n_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    d_d       = d_q;
    largest_d = largest_q;
    dist_d    = dist_q;
    found_d   = found_q;
    done_d    = 1'b0;
    answer_d  = answer_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d       = mag;
          d_d       = W'(3);
          largest_d = '0;
          dist_d    = '0;
          found_d   = 1'b0;
          state_d   = S_STRIP;
        end
      end
      // strip factors of two, one per cycle; zero falls straight through
      S_STRIP: begin
        if (n_q == '0) begin
          state_d = S_FINISH;
        end else if (!n_q[0]) begin
          n_d       = n_q >> 1;
          dist_d    = DistBits'(1);
          largest_d = W'(2);
        end else begin
          state_d = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (rem == '0) begin
            // d divides: remove it and try the same d again
            n_d     = quot;
            found_d = 1'b1;
            if (!found_q) begin
              dist_d    = dist_inc;
              largest_d = d_q;
            end
            state_d = S_DIV_GO;
          end else if (d_q > quot) begin
            // d*d > n: nothing left to try
            state_d = S_FINISH;
          end else begin
            d_d     = d_q + W'(2);
            found_d = 1'b0;
            state_d = S_DIV_GO;
          end
        end
      end
      S_FINISH: begin
        answer_d = (dist_fin == DistSat) ? largest_fin : '1;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    d_q       <= d_d;
    largest_q <= largest_d;
    dist_q    <= dist_d;
    found_q   <= found_d;
    answer_q  <= answer_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign answer_o = $signed(answer_q);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(state_q == S_FINISH))
    else $error("result strobe outside the finish step");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !done_o)
    else $error("accepted item did not raise busy");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV_WAIT)
    else $error("divider finished while controller not waiting");

  a_divisor_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> d_q[0] && d_q != W'(1))
    else $error("trial divisor not odd and above one");

endmodule

// File: tb/sv/tb_largest_prime_divisor_top.sv
`timescale 1ns / 1ps

module tb_largest_prime_divisor_top;
  import lpd_pkg::*;

  localparam int unsigned MagBits = 47;
  localparam int unsigned FieldBits = MagBits + 1;
  localparam longint unsigned FullMag = 64'd1 << MagBits;

  // Random items are built from small primes and a bounded cofactor. Trial
  // division then stops early (about 200 trials at most).
  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned RandomItems = 77;
  localparam int unsigned SettleCycles = 100;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  logic signed [MagBits:0] value_i;
  logic                  busy_o;
  logic                  done_o;
  logic signed [MagBits:0] answer_o;

  // Expected answers for accepted values, oldest first
  class lpd_answer_log;
    logic signed [MagBits:0] pending_answers[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Magnitude of the value, factored by trial division: 2 first, then odd
    // divisors while div*div <= rest. Each dividing prime is removed fully.
    static function logic signed [MagBits:0] largest_prime_of(
        logic signed [MagBits:0] value);
      logic [MagBits:0] raw;
      longint unsigned rest;
      longint unsigned div;
      longint unsigned top;
      int unsigned distinct;
      raw = value[MagBits] ? -value : value;
      rest = 64'(raw);
      top = 0;
      distinct = 0;
      if (rest == 0) return '1;
      if ((rest & 64'd1) == 0) begin
        while ((rest & 64'd1) == 0) rest = rest >> 1;
        distinct++;
        top = 2;
      end
      for (div = 3; div <= rest / div; div += 2) begin
        if (rest % div == 0) begin
          while (rest % div == 0) rest = rest / div;
          distinct++;
          top = div;
        end
      end
      if (rest > 1) begin
        distinct++;
        top = rest;
      end
      // fewer than two distinct primes gives all ones
      return (distinct > 1) ? FieldBits'(top) : '1;
    endfunction

    function void note_value(logic signed [MagBits:0] value);
      pending_answers.insert(pending_answers.size(), largest_prime_of(value));
    endfunction

    function void check_answer(logic signed [MagBits:0] got);
      logic signed [MagBits:0] want;
      if (pending_answers.size() == 0) begin
        $error("answer: none expected, got %0d", got);
        mismatches++;
        return;
      end
      want = pending_answers.pop_front();
      if (got !== want) begin
        $error("answer: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return pending_answers.size();
    endfunction
  endclass

  lpd_answer_log book = new();

  // Factor pool for random values; 2 and 3 weighted up for long strips
  int unsigned small_primes[$] = '{2, 2, 2, 3, 3, 5, 7, 11, 13, 17, 19, 23, 29,
                                   31, 37, 41, 43, 47, 53, 59, 61, 67, 71, 73,
                                   79, 83, 89, 97};

  // Edge cases first: zero, unit magnitudes, powers of two up to the most
  // negative value, prime powers, products of many primes, a big cofactor.
  logic signed [MagBits:0] directed_values[$] = '{
    48'sd0, 48'sd1, -48'sd1, 48'sd2, -48'sd2, 48'sd4, 48'sd6, -48'sd6,
    48'sd9, 48'sd35, 48'sd45, 48'sd97, 48'sd65521,
    48'sd80798284478113,           // 97^7
    48'sd68630377364883,           // 3^29
    48'sd137260754729766,          // 2 * 3^29
    -48'sd137260754729766,
    48'sd70368744177664,           // 2^46
    {1'b1, {MagBits{1'b0}}},       // most negative: magnitude 2^47
    48'sd7420738134810,            // primes 2..37 once each
    -48'sd7420738134810,
    48'sd1048579145728,            // 2^20 * 1000003
    -48'sd3000009
  };

  int unsigned cycle_count;

  largest_prime_divisor_top #(
    .MAG_BITS(MagBits)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .value_i (value_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .answer_o(answer_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Results last a single cycle and cannot be held off: check every strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) book.check_answer(answer_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Start stays high from the previous item if another follows at once.
  // busy_o only moves just after a rising edge, so reading it at the falling
  // edge tells whether the next rising edge takes the item.
  task automatic send_value(input logic signed [MagBits:0] value);
    @(negedge clk_i);
    start_i <= 1'b1;
    value_i <= value;
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    book.note_value(value);
  endtask

  // Start low, junk on the value bus
  task automatic idle_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      value_i <= FieldBits'({$urandom(), $urandom()});
    end
  endtask

  task automatic wait_for_answers();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (book.pending() != 0) @(negedge clk_i);
  endtask

  // Mostly cofactor up to 4095 times a random run of small primes, clipped
  // at 2^47; now and then a cofactor up to 65535, or a tiny magnitude.
  function automatic logic signed [MagBits:0] random_value();
    longint unsigned mag;
    longint unsigned prime;
    int unsigned pick;
    int unsigned steps;
    logic [MagBits:0] bits;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      mag = $urandom_range(0, 3);
    end else begin
      mag = (pick < 3) ? $urandom_range(2, 65535) : $urandom_range(1, 4095);
      steps = $urandom_range(0, 40);
      repeat (steps) begin
        prime = small_primes[$urandom_range(0, small_primes.size() - 1)];
        if (mag * prime <= FullMag) mag = mag * prime;
      end
    end
    bits = FieldBits'(mag);
    return $urandom_range(0, 1) ? -bits : bits;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    cycle_count = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    value_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
      if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 6));
    end
    // full drain before the random part
    wait_for_answers();

    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        send_value(random_value());
        sent++;
      end
      case ($urandom_range(0, 5))
        0:       wait_for_answers();
        1, 2:    ;
        default: idle_sender($urandom_range(1, 12));
      endcase
    end

    wait_for_answers();
    repeat (SettleCycles) @(negedge clk_i);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
